FILE: sv/adsr_pkg.sv
// ============================================================================
// adsr_pkg
// Shared constants and controller/datapath interface types for the linear
// ADSR envelope generator.
// ============================================================================
package adsr_pkg;

    // Default widths of the sample counters and of the envelope levels
    localparam int DEF_COUNT_WIDTH = 24;
    localparam int DEF_LEVEL_WIDTH = 16;

    // Configuration port geometry
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int PHASE_WIDTH     = 3;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PEAK    = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SUSTAIN = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ATTACK  = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DECAY   = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RELEASE = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NOTE    = 3'd5;

    // Phase codes reported with each amplitude
    localparam logic [PHASE_WIDTH-1:0] PH_ATTACK  = 3'd0;
    localparam logic [PHASE_WIDTH-1:0] PH_DECAY   = 3'd1;
    localparam logic [PHASE_WIDTH-1:0] PH_SUSTAIN = 3'd2;
    localparam logic [PHASE_WIDTH-1:0] PH_RELEASE = 3'd3;
    localparam logic [PHASE_WIDTH-1:0] PH_REJECT  = 3'd4;
    localparam logic [PHASE_WIDTH-1:0] PH_IDLE    = 3'd5;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch_in;   // capture the restart flag of an accepted transfer
        logic decide;     // form segment bounds and the note-fits flag
        logic classify;   // pick the segment, advance the sample counter
        logic multiply;   // form the interpolation product
        logic div_step;   // one quotient bit of the interpolation divide
        logic load_out;   // write the result into the output register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic div_last;   // current divide step produces the final bit
    } status_t;

endpackage

FILE: sv/adsr_ctrl.sv
// ============================================================================
// adsr_ctrl
// Sequencer for one sample: decide, classify, multiply, divide, then hand
// the result to the output register.
// ============================================================================
module adsr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output adsr_pkg::cmd_t    cmd,
    input  adsr_pkg::status_t status
);
    import adsr_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_CLASS  = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // Output register is free when empty or being drained this cycle
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_CLASS;
            end
            S_CLASS:
            begin
                cmd.classify = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.multiply = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/adsr_datapath.sv
// ============================================================================
// adsr_datapath
// Configuration registers, sample counter, segment selection, interpolation
// multiplier and a restoring divider that yields one quotient bit per cycle.
// ============================================================================
module adsr_datapath
#(
    parameter int COUNT_WIDTH = adsr_pkg::DEF_COUNT_WIDTH,
    parameter int LEVEL_WIDTH = adsr_pkg::DEF_LEVEL_WIDTH
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  adsr_pkg::cmd_t                        cmd,
    output adsr_pkg::status_t                     status,
    input  logic                                  cfg_write,
    input  logic [adsr_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [adsr_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    input  logic                                  restart,
    output logic [LEVEL_WIDTH-1:0]                amplitude,
    output logic [adsr_pkg::PHASE_WIDTH-1:0]      phase,
    output logic                                  last_sample
);
    import adsr_pkg::*;

    localparam int STEP_W   = $clog2(LEVEL_WIDTH);
    localparam int PROD_W   = LEVEL_WIDTH + COUNT_WIDTH;

    // Configuration registers
    logic [LEVEL_WIDTH-1:0] peak_reg;
    logic [LEVEL_WIDTH-1:0] sus_reg;
    logic [COUNT_WIDTH-1:0] atk_reg;
    logic [COUNT_WIDTH-1:0] dec_reg;
    logic [COUNT_WIDTH-1:0] rel_reg;
    logic [COUNT_WIDTH-1:0] note_reg;

    // Note state
    logic [COUNT_WIDTH-1:0] idx_reg;
    logic [COUNT_WIDTH-1:0] idx_next;
    logic                   active_reg;
    logic                   active_next;
    logic                   restart_reg;

    // Segment bounds
    logic                   fits_reg;
    logic [COUNT_WIDTH:0]   ad_reg;
    logic [COUNT_WIDTH-1:0] rs_reg;
    logic [COUNT_WIDTH+1:0] need;

    // Interpolation operands and staged result tags
    logic [LEVEL_WIDTH-1:0]  mag_reg;
    logic [LEVEL_WIDTH-1:0]  mag_next;
    logic [COUNT_WIDTH-1:0]  k_reg;
    logic [COUNT_WIDTH-1:0]  k_next;
    logic [COUNT_WIDTH-1:0]  div_reg;
    logic [COUNT_WIDTH-1:0]  div_next;
    logic [LEVEL_WIDTH-1:0]  base_reg;
    logic [LEVEL_WIDTH-1:0]  base_next;
    logic                    sub_reg;
    logic                    sub_next;
    logic [PHASE_WIDTH-1:0]  phase_reg;
    logic [PHASE_WIDTH-1:0]  phase_next;
    logic                    last_reg;
    logic                    last_next;

    // Classification signals
    logic [COUNT_WIDTH-1:0]  e_idx;
    logic [COUNT_WIDTH:0]    e_inc;
    logic                    act_now;
    logic                    end_now;

    // Divider
    logic [PROD_W-1:0]       prod;
    logic [COUNT_WIDTH-1:0]  rem_reg;
    logic [LEVEL_WIDTH-1:0]  quo_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [COUNT_WIDTH:0]    trial;
    logic [COUNT_WIDTH:0]    trial_diff;
    logic                    trial_ge;

    // Output register
    logic [LEVEL_WIDTH-1:0]  amp_out_reg;
    logic [PHASE_WIDTH-1:0]  phase_out_reg;
    logic                    last_out_reg;

    // ------------------------------------------------------------------
    // Configuration writes; out-of-range indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= '1;
            sus_reg  <= {1'b1, {(LEVEL_WIDTH-1){1'b0}}};
            atk_reg  <= '0;
            dec_reg  <= '0;
            rel_reg  <= '0;
            note_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PEAK:    peak_reg <= cfg_data[LEVEL_WIDTH-1:0];
                REG_SUSTAIN: sus_reg  <= cfg_data[LEVEL_WIDTH-1:0];
                REG_ATTACK:  atk_reg  <= cfg_data[COUNT_WIDTH-1:0];
                REG_DECAY:   dec_reg  <= cfg_data[COUNT_WIDTH-1:0];
                REG_RELEASE: rel_reg  <= cfg_data[COUNT_WIDTH-1:0];
                REG_NOTE:    note_reg <= cfg_data[COUNT_WIDTH-1:0];
                default:     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Segment bounds; sum is wide enough that it cannot wrap
    assign need = {2'b00, atk_reg} + {2'b00, dec_reg} + {2'b00, rel_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            restart_reg <= restart;
        end
        if (cmd.decide)
        begin
            fits_reg <= (note_reg != '0) && ({2'b00, note_reg} >= need);
            ad_reg   <= {1'b0, atk_reg} + {1'b0, dec_reg};
            rs_reg   <= note_reg - rel_reg;
        end
    end

    // ------------------------------------------------------------------
    // Classification: which segment this sample sits in, and the counter
    assign e_idx   = restart_reg ? '0 : idx_reg;
    assign e_inc   = {1'b0, e_idx} + 1'b1;
    assign end_now = (e_inc >= {1'b0, note_reg});

    always_comb
    begin
        if (restart_reg)
        begin
            act_now = fits_reg;
        end
        else
        begin
            act_now = active_reg && fits_reg && (idx_reg < note_reg);
        end
    end

    always_comb
    begin
        mag_next   = '0;
        k_next     = '0;
        div_next   = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
        base_next  = '0;
        sub_next   = 1'b0;
        phase_next = PH_IDLE;
        last_next  = 1'b0;
        idx_next   = e_idx;
        active_next = 1'b0;

        if (restart_reg && !fits_reg)
        begin
            // too short or empty note
            phase_next = PH_REJECT;
            last_next  = 1'b1;
        end
        else if (act_now)
        begin
            last_next   = end_now;
            active_next = !end_now;
            idx_next    = end_now ? '0 : e_inc[COUNT_WIDTH-1:0];

            if (e_idx < atk_reg)
            begin
                phase_next = PH_ATTACK;
                mag_next   = peak_reg;
                k_next     = e_idx;
                div_next   = atk_reg;
            end
            else if ({1'b0, e_idx} < ad_reg)
            begin
                phase_next = PH_DECAY;
                k_next     = e_idx - atk_reg;
                div_next   = dec_reg;
                base_next  = peak_reg;
                if (peak_reg >= sus_reg)
                begin
                    mag_next = peak_reg - sus_reg;
                    sub_next = 1'b1;
                end
                else
                begin
                    mag_next = sus_reg - peak_reg;
                end
            end
            else if (e_idx < rs_reg)
            begin
                phase_next = PH_SUSTAIN;
                base_next  = sus_reg;
            end
            else
            begin
                phase_next = PH_RELEASE;
                mag_next   = sus_reg;
                k_next     = e_idx - rs_reg;
                div_next   = rel_reg;
                base_next  = sus_reg;
                sub_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            active_reg <= 1'b0;
        end
        else if (cmd.classify)
        begin
            idx_reg    <= idx_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.classify)
        begin
            mag_reg   <= mag_next;
            k_reg     <= k_next;
            div_reg   <= div_next;
            base_reg  <= base_next;
            sub_reg   <= sub_next;
            phase_reg <= phase_next;
            last_reg  <= last_next;
        end
    end

    // ------------------------------------------------------------------
    // Product, then restoring divide. The quotient is below 2^LEVEL_WIDTH,
    // so the upper product bits start as a partial remainder below div.
    assign prod = {{COUNT_WIDTH{1'b0}}, mag_reg} * {{LEVEL_WIDTH{1'b0}}, k_reg};

    assign trial      = {rem_reg, quo_reg[LEVEL_WIDTH-1]};
    assign trial_ge   = (trial >= {1'b0, div_reg});
    assign trial_diff = trial - {1'b0, div_reg};

    assign status.div_last = (step_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.multiply)
        begin
            rem_reg  <= prod[PROD_W-1:LEVEL_WIDTH];
            quo_reg  <= prod[LEVEL_WIDTH-1:0];
            step_reg <= STEP_W'(LEVEL_WIDTH - 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= trial_ge ? trial_diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
            quo_reg  <= {quo_reg[LEVEL_WIDTH-2:0], trial_ge};
            step_reg <= step_reg - 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            amp_out_reg   <= sub_reg ? (base_reg - quo_reg) : (base_reg + quo_reg);
            phase_out_reg <= phase_reg;
            last_out_reg  <= last_reg;
        end
    end

    assign amplitude   = amp_out_reg;
    assign phase       = phase_out_reg;
    assign last_sample = last_out_reg;

endmodule

FILE: sv/adsr_envelope_generator.sv
// ============================================================================
// adsr_envelope_generator
// Each tick runs through decide, classify, multiply and the divider, which
// retires one quotient bit per cycle; a new tick is taken only when idle,
// after the previous result is loaded into a free output register.
// Reset: registers take their default levels and zero lengths, no note is
// active, and the output register is empty.
// ============================================================================
module adsr_envelope_generator
#(
    parameter int COUNT_WIDTH = adsr_pkg::DEF_COUNT_WIDTH,
    parameter int LEVEL_WIDTH = adsr_pkg::DEF_LEVEL_WIDTH
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [adsr_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [adsr_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    // sample tick channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  restart,
    // envelope channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [LEVEL_WIDTH-1:0]                amplitude,
    output logic [adsr_pkg::PHASE_WIDTH-1:0]      phase,
    output logic                                  last_sample
);
    import adsr_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Register writes always complete in one transfer
    assign cfg_ready = 1'b1;

    adsr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    adsr_datapath
    #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .LEVEL_WIDTH (LEVEL_WIDTH)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .restart     (restart),
        .amplitude   (amplitude),
        .phase       (phase),
        .last_sample (last_sample)
    );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: envelope generator testbench
// Drives sample ticks and register writes through valid/ready channels, with
// random idle gaps between ticks and random output stalls. A local model of the envelope computes the
// amplitude, phase and last-sample flag of every tick transfer. Each output
// transfer is compared against the oldest pending envelope value.
// ----------------------------------------------------------------------------
module tb_top;
    import adsr_pkg::*;

    localparam int LEVEL_W = DEF_LEVEL_WIDTH;
    localparam int COUNT_W = DEF_COUNT_WIDTH;

    // writes to these indexes must leave every register alone
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_HI = 3'd7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [LEVEL_W-1:0]     amp;
        logic [PHASE_WIDTH-1:0] ph;
        logic                   last;
    } envelope_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       restart = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [LEVEL_W-1:0]         amplitude;
    logic [PHASE_WIDTH-1:0]     phase;
    logic                       last_sample;

    // envelope model state and registers
    logic [LEVEL_W-1:0] cur_peak;
    logic [LEVEL_W-1:0] cur_sus;
    logic [COUNT_W-1:0] len_attack;
    logic [COUNT_W-1:0] len_decay;
    logic [COUNT_W-1:0] len_release;
    logic [COUNT_W-1:0] len_note;
    logic [COUNT_W-1:0] next_sample;
    bit                 note_on;

    envelope_t pending_env[$];

    int  error_count = 0;
    int  ticks_sent = 0;
    int  reg_writes = 0;
    int  envelopes_checked = 0;
    int  phase_hits[6];
    bit  quiet = 1'b0;
    int  hold_left = 0;
    int  stall_left = 0;

    adsr_envelope_generator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .amplitude   (amplitude),
        .phase       (phase),
        .last_sample (last_sample)
    );

    // 10 ns clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #8_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // envelope model
    // ------------------------------------------------------------------
    function automatic void reset_model();
        cur_peak    = '1;
        cur_sus     = 16'h8000;
        len_attack  = '0;
        len_decay   = '0;
        len_release = '0;
        len_note    = '0;
        next_sample = '0;
        note_on     = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                      input logic [CFG_DATA_WIDTH-1:0] data);
        case (idx)
            REG_PEAK:    cur_peak    = data[LEVEL_W-1:0];
            REG_SUSTAIN: cur_sus     = data[LEVEL_W-1:0];
            REG_ATTACK:  len_attack  = data[COUNT_W-1:0];
            REG_DECAY:   len_decay   = data[COUNT_W-1:0];
            REG_RELEASE: len_release = data[COUNT_W-1:0];
            REG_NOTE:    len_note    = data[COUNT_W-1:0];
            default:     ;
        endcase
    endfunction

    // advance the model by one tick and return the envelope it answers
    function automatic envelope_t next_envelope(input bit restart_flag);
        envelope_t  r;
        logic [63:0] need, a_end, d_end, r_start, pk, su, idx, lvl;
        bit          fits;
        r      = '0;
        r.ph   = PH_IDLE;
        need   = 64'(len_attack) + 64'(len_decay) + 64'(len_release);
        fits   = (len_note != '0) && (64'(len_note) >= need);
        if (restart_flag)
        begin
            next_sample = '0;
            note_on     = 1'b1;
            if (!fits)
            begin
                note_on = 1'b0;
                r.ph    = PH_REJECT;
                r.last  = 1'b1;
            end
        end
        else if (note_on && (!fits || next_sample >= len_note))
        begin
            note_on = 1'b0;
        end

        if (note_on)
        begin
            a_end   = 64'(len_attack);
            d_end   = 64'(len_attack) + 64'(len_decay);
            r_start = 64'(len_note) - 64'(len_release);
            pk      = 64'(cur_peak);
            su      = 64'(cur_sus);
            idx     = 64'(next_sample);
            if (idx < a_end)
            begin
                r.ph = PH_ATTACK;
                lvl  = (pk * idx) / a_end;
            end
            else if (idx < d_end)
            begin
                r.ph = PH_DECAY;
                if (pk >= su)
                    lvl = pk - ((pk - su) * (idx - a_end)) / 64'(len_decay);
                else
                    lvl = pk + ((su - pk) * (idx - a_end)) / 64'(len_decay);
            end
            else if (idx < r_start)
            begin
                r.ph = PH_SUSTAIN;
                lvl  = su;
            end
            else
            begin
                r.ph = PH_RELEASE;
                lvl  = su - (su * (idx - r_start)) / 64'(len_release);
            end
            r.amp = lvl[LEVEL_W-1:0];
            if (64'(next_sample) + 64'd1 >= 64'(len_note))
            begin
                r.last      = 1'b1;
                note_on     = 1'b0;
                next_sample = '0;
            end
            else
            begin
                next_sample = next_sample + 1'b1;
            end
        end
        return r;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return LEVEL_W'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------

    // one tick transfer; returns at the falling edge after the transfer
    task automatic send_tick(input bit restart_flag);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        restart  <= restart_flag;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        pending_env.push_back(next_envelope(restart_flag));
        phase_hits[pending_env[$].ph]++;
        ticks_sent++;
        @(negedge clk);
    endtask

    // one register transfer; valid stays up for a following write
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        apply_reg(idx, data);
        reg_writes++;
        @(negedge clk);
    endtask

    // stop offering ticks and wait until every envelope value came back
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_env.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_WIDTH-1:0] pk,
                             input logic [CFG_DATA_WIDTH-1:0] su,
                             input logic [CFG_DATA_WIDTH-1:0] att,
                             input logic [CFG_DATA_WIDTH-1:0] dec,
                             input logic [CFG_DATA_WIDTH-1:0] rel,
                             input logic [CFG_DATA_WIDTH-1:0] len);
        settle();
        write_reg(REG_PEAK, pk);
        write_reg(REG_SUSTAIN, su);
        write_reg(REG_ATTACK, att);
        write_reg(REG_DECAY, dec);
        write_reg(REG_RELEASE, rel);
        write_reg(REG_NOTE, len);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // output side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    // compare every output transfer with the oldest pending value
    always @(posedge clk)
    begin : check_envelope
        envelope_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_env.size() == 0)
            begin
                $error("envelope output with nothing pending: amp %0h phase %0d last %0b",
                       amplitude, phase, last_sample);
                error_count++;
            end
            else
            begin
                want = pending_env.pop_front();
                envelopes_checked++;
                if (amplitude !== want.amp)
                begin
                    $error("amplitude: expected %0h, got %0h", want.amp, amplitude);
                    error_count++;
                end
                if (phase !== want.ph)
                begin
                    $error("phase: expected %0d, got %0d", want.ph, phase);
                    error_count++;
                end
                if (last_sample !== want.last)
                begin
                    $error("last_sample: expected %0b, got %0b", want.last, last_sample);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // defaults after reset: idle tick, then an empty note is rejected
    task automatic test_reset_defaults();
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    // full note through all four segments, then an idle tick
    task automatic test_full_note();
        int k;
        configure(32'hFFFF, 32'h1234, 3, 2, 3, 10);
        send_tick(1'b1);
        for (k = 0; k < 10; k++)
            send_tick(1'b0);
    endtask

    // sustain above peak (rising decay), and all segments of zero length
    task automatic test_rising_and_empty_segments();
        int k;
        configure(32'h0100, 32'hFFFF, 0, 3, 0, 4);
        send_tick(1'b1);
        for (k = 0; k < 3; k++)
            send_tick(1'b0);
        configure(32'h0, 32'hFFFF, 0, 0, 0, 1);
        send_tick(1'b1);
    endtask

    // register extremes, with junk in the bits above each register
    task automatic test_register_extremes();
        configure('1, '1, '1, '1, '1, '1);
        send_tick(1'b1);
        configure('1, 32'h0, '1, 0, 0, '1);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // restart in mid note, ignored indexes, note cut short by a write
    task automatic test_mid_note();
        int k;
        configure(32'hFFFF, 32'h4000, 2, 2, 2, 8);
        send_tick(1'b1);
        for (k = 0; k < 3; k++)
            send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        settle();
        write_reg(REG_UNUSED_LO, $urandom);
        write_reg(REG_UNUSED_HI, '1);
        write_reg(REG_NOTE, 2);
        cfg_valid <= 1'b0;
        send_tick(1'b0);
    endtask

    // receiver holds off while ticks keep coming
    task automatic test_output_hold();
        int k;
        configure(32'hC000, 32'h3000, 2, 2, 2, 12);
        quiet     = 1'b1;
        hold_left = 300;
        send_tick(1'b1);
        for (k = 0; k < 14; k++)
            send_tick(1'b0);
        quiet = 1'b0;
        settle();
    endtask

    // random settings, each followed by mostly whole notes
    task automatic test_random_notes();
        int p, k, kind, slot;
        logic [COUNT_W-1:0] len[3];
        logic [COUNT_W-1:0] n;
        logic [LEVEL_W-1:0] pk, su;
        logic [31:0] sum;
        bit flag;
        for (p = 0; p < 20; p++)
        begin
            settle();
            kind = $urandom_range(0, 99);
            pk   = pick_level();
            su   = pick_level();
            for (k = 0; k < 3; k++)
                len[k] = $urandom_range(0, 6);
            if (kind >= 70 && kind < 85)
            begin
                // one long segment, the others short
                slot      = $urandom_range(0, 2);
                len[slot] = COUNT_W'($urandom);
            end
            else if (kind >= 85)
            begin
                for (k = 0; k < 3; k++)
                    len[k] = $urandom_range(0, 1) ? COUNT_MAX : '0;
            end
            sum = 32'(len[0]) + 32'(len[1]) + 32'(len[2]);
            if ($urandom_range(0, 9) == 0)
                n = (sum > 0) ? COUNT_W'($urandom_range(0, sum - 1)) : '0;
            else if (kind >= 85 && $urandom_range(0, 1))
                n = COUNT_MAX;
            else
                n = COUNT_W'(sum + $urandom_range(0, 10));

            write_reg(REG_PEAK, {16'($urandom), pk});
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO, $urandom);
            write_reg(REG_SUSTAIN, {16'($urandom), su});
            write_reg(REG_ATTACK, {8'($urandom), len[0]});
            write_reg(REG_DECAY, {8'($urandom), len[1]});
            write_reg(REG_RELEASE, {8'($urandom), len[2]});
            write_reg(REG_NOTE, {8'($urandom), n});
            cfg_valid <= 1'b0;

            quiet = (p % 4 == 3);
            for (k = 0; k < 35; k++)
            begin
                if (k == 0)
                    flag = 1'b1;
                else if (!note_on)
                    flag = ($urandom_range(0, 2) == 0);
                else
                    flag = ($urandom_range(0, 39) == 0);
                send_tick(flag);
            end
            quiet = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        reset_model();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_full_note();
        test_rising_and_empty_segments();
        test_register_extremes();
        test_mid_note();
        test_output_hold();
        test_random_notes();

        settle();
        repeat (40) @(posedge clk);

        $display("Sent %0d ticks and %0d register writes; checked %0d envelope values.",
                 ticks_sent, reg_writes, envelopes_checked);
        $display("Phases: attack %0d decay %0d sustain %0d release %0d rejected %0d idle %0d",
                 phase_hits[PH_ATTACK], phase_hits[PH_DECAY], phase_hits[PH_SUSTAIN],
                 phase_hits[PH_RELEASE], phase_hits[PH_REJECT], phase_hits[PH_IDLE]);
        if (error_count == 0 && pending_env.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

FILE: sim.f
sv/adsr_pkg.sv
sv/adsr_ctrl.sv
sv/adsr_datapath.sv
sv/adsr_envelope_generator.sv
bench/tb_top.sv
